>>> hdl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the key/value table
// Opcodes, field widths, configuration reset and default sizes.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int FIELD_W  = 32;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

    // write enables of the entry store
    typedef struct packed {
        logic key_we;
        logic val_we;
        logic rank_we;
    } t_store_we;

endpackage

>>> hdl/lkv_store.sv
// ----------------------------------------------------------------------------
// lkv_store: entry store of the key/value table
// Key, value and recency rank memories, one write and one registered read.
// ----------------------------------------------------------------------------
module lkv_store #(
    parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  lkv_pkg::t_store_we          i_we,
    input  logic [$clog2(ENTRIES)-1:0]  i_wr_addr,
    input  logic [KEY_BITS-1:0]         i_wr_key,
    input  logic [VALUE_BITS-1:0]       i_wr_val,
    input  logic [$clog2(ENTRIES)-1:0]  i_wr_rank,
    input  logic [$clog2(ENTRIES)-1:0]  i_rd_addr,
    output logic [KEY_BITS-1:0]         o_rd_key,
    output logic [VALUE_BITS-1:0]       o_rd_val,
    output logic [$clog2(ENTRIES)-1:0]  o_rd_rank
);

    localparam int RW = $clog2(ENTRIES);

    logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
    logic [RW-1:0]         rank_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we.key_we) begin
            key_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_we.val_we) begin
            val_mem[i_wr_addr] <= i_wr_val;
        end
        if (i_we.rank_we) begin
            rank_mem[i_wr_addr] <= i_wr_rank;
        end
        o_rd_key  <= key_mem[i_rd_addr];
        o_rd_val  <= val_mem[i_rd_addr];
        o_rd_rank <= rank_mem[i_rd_addr];
    end

endmodule

>>> hdl/lru_key_value_table.sv
// ----------------------------------------------------------------------------
// lru_key_value_table: fully associative key/value table, oldest-insert eviction
// All operations but clear walk the entries through one key comparator and rank unit.
// ----------------------------------------------------------------------------
// Steps: clear empties the table without a walk; find and remove scan every entry,
//   a remove that hits walks again to drop it; insert scans, then refreshes a known
//   key or writes a new one, evicting first if full, then evicts down to capacity.
// busy drops as the strobe rises, so the next item is taken at the edge ending
// the strobe cycle; the entry walks, one slot a cycle, set the rate.
// Synchronous active-low reset empties the table and sets capacity to 16; no stall.
module lru_key_value_table #(
    parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lkv_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [lkv_pkg::FIELD_W-1:0]       i_lookup_key,
    input  logic [lkv_pkg::FIELD_W-1:0]       i_new_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]         i_cfg_data,
    output logic                              o_strobe,
    output logic                              o_found,
    output logic [lkv_pkg::FIELD_W-1:0]       o_read_value,
    output logic [$clog2(ENTRIES+1)-1:0]      o_occupancy
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int RW   = IW;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_HITUPD = 3'd2;
    localparam logic [2:0] S_DROP   = 3'd3;
    localparam logic [2:0] S_EVICT  = 3'd4;
    localparam logic [2:0] S_WRNEW  = 3'd5;
    localparam logic [2:0] S_CHECK  = 3'd6;

    // control state
    logic [2:0]                   r_state, n_state;
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_pvld, n_pvld;
    logic [ENTRIES-1:0]           r_valid, n_valid;
    logic [CW-1:0]                r_count, n_count;
    logic [lkv_pkg::CAP_W-1:0]    r_cap, n_cap;
    logic                         r_strobe, n_strobe;
    logic                         r_pend_new, n_pend_new;
    logic                         r_hit, n_hit;
    logic                         r_free_ok, n_free_ok;

    // item payload and scan results
    logic [lkv_pkg::OPCODE_W-1:0] r_op, n_op;
    logic [KEY_BITS-1:0]          r_key, n_key;
    logic [VALUE_BITS-1:0]        r_val, n_val;
    logic [IW-1:0]                r_pidx, n_pidx;
    logic [IW-1:0]                r_hit_slot, n_hit_slot;
    logic [RW-1:0]                r_hit_rank, n_hit_rank;
    logic [VALUE_BITS-1:0]        r_hit_val, n_hit_val;
    logic [IW-1:0]                r_free_slot, n_free_slot;
    logic [IW-1:0]                r_old_slot, n_old_slot;
    logic                         r_found, n_found;
    logic [VALUE_BITS-1:0]        r_read_value, n_read_value;

    lkv_pkg::t_store_we           st_we;
    logic [IW-1:0]                st_wr_addr;
    logic [RW-1:0]                st_wr_rank;
    logic [KEY_BITS-1:0]          rd_key;
    logic [VALUE_BITS-1:0]        rd_val;
    logic [RW-1:0]                rd_rank;

    logic                         slot_v;
    logic                         key_eq;
    logic                         rank_zero;
    logic                         rank_above;
    logic [RW-1:0]                rank_dec;
    logic                         pass_last;
    logic                         over_cap;

    lkv_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_we       (st_we),
        .i_wr_addr  (st_wr_addr),
        .i_wr_key   (r_key),
        .i_wr_val   (r_val),
        .i_wr_rank  (st_wr_rank),
        .i_rd_addr  (r_idx[IW-1:0]),
        .o_rd_key   (rd_key),
        .o_rd_val   (rd_val),
        .o_rd_rank  (rd_rank)
    );

    assign slot_v     = r_pvld && r_valid[r_pidx];
    assign key_eq     = (rd_key == r_key);
    assign rank_zero  = (rd_rank == '0);
    assign rank_above = (rd_rank > r_hit_rank);
    assign rank_dec   = rd_rank - RW'(1);
    assign pass_last  = (r_idx == CW'(ENTRIES));
    assign over_cap   = (CMPW'(r_count) > CMPW'(r_cap));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pvld       = r_pvld;
        n_valid      = r_valid;
        n_count      = r_count;
        n_cap        = r_cap;
        n_strobe     = 1'b0;
        n_pend_new   = r_pend_new;
        n_hit        = r_hit;
        n_free_ok    = r_free_ok;
        n_op         = r_op;
        n_key        = r_key;
        n_val        = r_val;
        n_pidx       = r_idx[IW-1:0];
        n_hit_slot   = r_hit_slot;
        n_hit_rank   = r_hit_rank;
        n_hit_val    = r_hit_val;
        n_free_slot  = r_free_slot;
        n_old_slot   = r_old_slot;
        n_found      = r_found;
        n_read_value = r_read_value;
        st_we        = '0;
        st_wr_addr   = r_pidx;
        st_wr_rank   = rank_dec;

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end

        // walk counter: issue one slot a cycle, process it the cycle after
        if (r_state != S_IDLE && r_state != S_WRNEW && r_state != S_CHECK) begin
            if (pass_last) begin
                n_idx  = '0;
                n_pvld = 1'b0;
            end else begin
                n_idx  = r_idx + CW'(1);
                n_pvld = 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op         = i_opcode;
                    n_key        = KEY_BITS'(i_lookup_key);
                    n_val        = VALUE_BITS'(i_new_value);
                    n_hit        = 1'b0;
                    n_free_ok    = 1'b0;
                    n_pend_new   = 1'b0;
                    n_idx        = '0;
                    n_pvld       = 1'b0;
                    n_found      = 1'b0;
                    n_read_value = '0;
                    if (i_opcode == lkv_pkg::OP_CLEAR) begin
                        n_valid  = '0;
                        n_count  = '0;
                        n_strobe = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (slot_v && key_eq && !r_hit) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_pidx;
                    n_hit_rank = rd_rank;
                    n_hit_val  = rd_val;
                end
                if (r_pvld && !r_valid[r_pidx] && !r_free_ok) begin
                    n_free_ok   = 1'b1;
                    n_free_slot = r_pidx;
                end
                if (slot_v && rank_zero) begin
                    n_old_slot = r_pidx;
                end
                if (pass_last) begin
                    unique case (r_op)
                        lkv_pkg::OP_INSERT: begin
                            if (n_hit) begin
                                n_state = S_HITUPD;
                            end else if (r_count >= CW'(ENTRIES)) begin
                                n_pend_new = 1'b1;
                                n_state    = S_EVICT;
                            end else begin
                                n_state = S_WRNEW;
                            end
                        end
                        lkv_pkg::OP_FIND: begin
                            n_found      = n_hit;
                            n_read_value = n_hit ? n_hit_val : '0;
                            n_strobe     = 1'b1;
                            n_state      = S_IDLE;
                        end
                        lkv_pkg::OP_REMOVE: begin
                            if (n_hit) begin
                                n_state = S_DROP;
                            end else begin
                                n_strobe = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                        lkv_pkg::OP_CLEAR: begin
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_HITUPD: begin
                if (slot_v) begin
                    if (r_pidx == r_hit_slot) begin
                        // refreshed entry becomes the youngest
                        st_we.val_we  = 1'b1;
                        st_we.rank_we = 1'b1;
                        st_wr_rank    = RW'(r_count - CW'(1));
                    end else if (rank_above) begin
                        st_we.rank_we = 1'b1;
                    end
                end
                if (pass_last) begin
                    n_state = S_CHECK;
                end
            end
            S_DROP: begin
                if (slot_v) begin
                    if (r_pidx == r_hit_slot) begin
                        n_valid[r_pidx] = 1'b0;
                    end else if (rank_above) begin
                        st_we.rank_we = 1'b1;
                    end
                end
                if (pass_last) begin
                    n_count  = r_count - CW'(1);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_EVICT: begin
                // oldest entry leaves, every other entry ages down by one
                if (slot_v) begin
                    if (rank_zero) begin
                        n_valid[r_pidx] = 1'b0;
                    end else begin
                        st_we.rank_we = 1'b1;
                    end
                end
                if (pass_last) begin
                    n_count = r_count - CW'(1);
                    if (r_pend_new) begin
                        n_state = S_WRNEW;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_WRNEW: begin
                st_we      = '1;
                st_wr_addr = r_free_ok ? r_free_slot : r_old_slot;
                st_wr_rank = RW'(r_count);
                n_valid[st_wr_addr] = 1'b1;
                n_count    = r_count + CW'(1);
                n_pend_new = 1'b0;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (over_cap) begin
                    n_state = S_EVICT;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_pvld     <= 1'b0;
            r_valid    <= '0;
            r_count    <= '0;
            r_cap      <= lkv_pkg::CAP_RESET;
            r_strobe   <= 1'b0;
            r_pend_new <= 1'b0;
            r_hit      <= 1'b0;
            r_free_ok  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_pvld     <= n_pvld;
            r_valid    <= n_valid;
            r_count    <= n_count;
            r_cap      <= n_cap;
            r_strobe   <= n_strobe;
            r_pend_new <= n_pend_new;
            r_hit      <= n_hit;
            r_free_ok  <= n_free_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_val        <= n_val;
        r_pidx       <= n_pidx;
        r_hit_slot   <= n_hit_slot;
        r_hit_rank   <= n_hit_rank;
        r_hit_val    <= n_hit_val;
        r_free_slot  <= n_free_slot;
        r_old_slot   <= n_old_slot;
        r_found      <= n_found;
        r_read_value <= n_read_value;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_strobe     = r_strobe;
    assign o_found      = r_found;
    assign o_read_value = lkv_pkg::FIELD_W'(r_read_value);
    assign o_occupancy  = r_count;

endmodule
